@@ sv/dos_pkg.sv @@
// Shared types, constants and register codes for the disparity/depth outlier stats block.
// No dependencies.
package dos_pkg;

    localparam int CNT_W = 23;
    localparam int ERR_W = 38;
    localparam int THR_MAX = 4;
    localparam int LHS_W = 41;
    localparam int RHS_W = 48;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam int MAX_FRAME_PIXELS_DEF = 4194304;
    localparam int NUM_THRESHOLDS_DEF = 4;

    localparam logic [2:0] REG_LEFT_SKIP = 3'd0;
    localparam logic [2:0] REG_MASK_EN = 3'd1;
    localparam logic [2:0] REG_THR_FIRST = 3'd2;
    localparam logic [2:0] REG_THR_SECOND = 3'd3;
    localparam logic [2:0] REG_THR_THIRD = 3'd4;
    localparam logic [2:0] REG_THR_FOURTH = 3'd5;

    typedef struct packed {
        logic [15:0]        gt_disparity;
        logic signed [15:0] gen_disparity;
        logic [11:0]        column;
        logic               mask_bit;
        logic               frame_end;
    } t_in_word;

    typedef struct packed {
        logic [CNT_W-1:0] valid_gt_count;
        logic [CNT_W-1:0] valid_gen_count;
        logic [CNT_W-1:0] outliers_all_first;
        logic [CNT_W-1:0] outliers_all_second;
        logic [CNT_W-1:0] outliers_all_third;
        logic [CNT_W-1:0] outliers_all_fourth;
        logic [CNT_W-1:0] outliers_gen_first;
        logic [CNT_W-1:0] outliers_gen_second;
        logic [CNT_W-1:0] outliers_gen_third;
        logic [CNT_W-1:0] outliers_gen_fourth;
        logic [ERR_W-1:0] error_sum_all;
        logic [ERR_W-1:0] error_sum_gen;
    } t_out_word;

    typedef struct packed {
        logic [11:0]                  left_skip;
        logic                         mask_enable;
        logic [THR_MAX-1:0][31:0]     thr;
    } t_cfg;

    typedef struct packed {
        logic                         counted;
        logic                         gen_ok;
        logic                         frame_end;
        logic [15:0]                  err;
        logic [LHS_W-1:0]             lhs;
        logic [THR_MAX-1:0][RHS_W-1:0] rhs;
    } t_prod;

endpackage

@@ sv/disparity_depth_outlier_stats_top.sv @@
// An accepted end-of-frame word moves through the product register into the result
// register. Throughput: one pixel word per cycle while o_in_stall is low; input, product
// and result registers in a row, the tallies load at the same edge as the result register.
// The input side stalls only when an end-of-frame word reaches the tally stage while the
// result register still holds a stalled word.
// Synchronous active-low reset clears the config registers, the tallies and all valid flags.
// Depends on dos_pkg, dos_prod, dos_accum.
module disparity_depth_outlier_stats_top #(
    parameter int MAX_FRAME_PIXELS = dos_pkg::MAX_FRAME_PIXELS_DEF,
    parameter int NUM_THRESHOLDS   = dos_pkg::NUM_THRESHOLDS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dos_pkg::ADDR_W-1:0]  paddr,
    input  logic [dos_pkg::DATA_W-1:0]  pwdata,
    output logic [dos_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  dos_pkg::t_in_word           i_in_word,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output dos_pkg::t_out_word          o_out_word
);

    dos_pkg::t_cfg     r_cfg;
    logic [2:0]        reg_idx;
    logic              wr_en;

    logic              r_s0_valid;
    dos_pkg::t_in_word r_s0_word;
    logic              s1_valid;
    dos_pkg::t_prod    s1_prod;
    logic              take;
    logic              s1_ready;
    logic              s0_ready;

    assign pready  = 1'b1;
    assign reg_idx = paddr[dos_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                dos_pkg::REG_LEFT_SKIP:  r_cfg.left_skip   <= pwdata[11:0];
                dos_pkg::REG_MASK_EN:    r_cfg.mask_enable <= pwdata[0];
                dos_pkg::REG_THR_FIRST:  r_cfg.thr[0]      <= pwdata;
                dos_pkg::REG_THR_SECOND: r_cfg.thr[1]      <= pwdata;
                dos_pkg::REG_THR_THIRD:  r_cfg.thr[2]      <= pwdata;
                dos_pkg::REG_THR_FOURTH: r_cfg.thr[3]      <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            dos_pkg::REG_LEFT_SKIP:  prdata = {20'd0, r_cfg.left_skip};
            dos_pkg::REG_MASK_EN:    prdata = {31'd0, r_cfg.mask_enable};
            dos_pkg::REG_THR_FIRST:  prdata = r_cfg.thr[0];
            dos_pkg::REG_THR_SECOND: prdata = r_cfg.thr[1];
            dos_pkg::REG_THR_THIRD:  prdata = r_cfg.thr[2];
            dos_pkg::REG_THR_FOURTH: prdata = r_cfg.thr[3];
            default:                 prdata = '0;
        endcase
    end

    assign s1_ready   = !s1_valid || take;
    assign s0_ready   = !r_s0_valid || s1_ready;
    assign o_in_stall = !s0_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (s0_ready) begin
            r_s0_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_ready && i_in_valid) begin
            r_s0_word <= i_in_word;
        end
    end

    dos_prod #(
        .NUM_THRESHOLDS (NUM_THRESHOLDS)
    ) u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s1_ready),
        .i_valid (r_s0_valid),
        .i_pix   (r_s0_word),
        .i_cfg   (r_cfg),
        .o_valid (s1_valid),
        .o_prod  (s1_prod)
    );

    dos_accum #(
        .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS),
        .NUM_THRESHOLDS   (NUM_THRESHOLDS)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s1_valid),
        .i_prod      (s1_prod),
        .o_take      (take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

@@ sv/dos_prod.sv @@
// Product stage: pixel qualification, error and the outlier test products.
// Depends on dos_pkg.
module dos_prod #(
    parameter int NUM_THRESHOLDS = dos_pkg::NUM_THRESHOLDS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  dos_pkg::t_in_word i_pix,
    input  dos_pkg::t_cfg    i_cfg,
    output logic             o_valid,
    output dos_pkg::t_prod   o_prod
);

    logic                r_valid;
    dos_pkg::t_prod      r_prod;
    dos_pkg::t_prod      n_prod;

    logic                gen_ok;
    logic [15:0]         genpos;
    logic [15:0]         absgen;
    logic signed [17:0]  d;
    logic [16:0]         diff;
    logic [32:0]         dg;

    always_comb begin
        gen_ok = !i_pix.gen_disparity[15];
        genpos = gen_ok ? 16'(i_pix.gen_disparity) : 16'd0;
        absgen = gen_ok ? 16'(i_pix.gen_disparity) : 16'(-i_pix.gen_disparity);
        d = 18'(i_pix.gen_disparity) - $signed({2'b00, i_pix.gt_disparity});
        diff = d[17] ? 17'(-d) : 17'(d);
        dg = 33'(diff) * 33'(i_pix.gt_disparity);

        n_prod.counted = (i_pix.column >= i_cfg.left_skip)
                         && !(i_cfg.mask_enable && !i_pix.mask_bit)
                         && (i_pix.gt_disparity != 16'd0);
        n_prod.gen_ok = gen_ok;
        n_prod.frame_end = i_pix.frame_end;
        n_prod.err = (i_pix.gt_disparity >= genpos) ? i_pix.gt_disparity - genpos
                                                    : genpos - i_pix.gt_disparity;
        n_prod.lhs = {dg, 8'd0};
        for (int k = 0; k < dos_pkg::THR_MAX; k++) begin
            if (k < NUM_THRESHOLDS) begin
                n_prod.rhs[k] = dos_pkg::RHS_W'(i_cfg.thr[k]) * dos_pkg::RHS_W'(absgen);
            end else begin
                n_prod.rhs[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;

endmodule

@@ sv/dos_accum.sv @@
// Tally stage: outlier compares, saturating counters and sums, result word register.
// Depends on dos_pkg.
module dos_accum #(
    parameter int MAX_FRAME_PIXELS = dos_pkg::MAX_FRAME_PIXELS_DEF,
    parameter int NUM_THRESHOLDS   = dos_pkg::NUM_THRESHOLDS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  dos_pkg::t_prod     i_prod,
    output logic               o_take,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output dos_pkg::t_out_word o_out_word
);

    localparam longint CNT_MAX = (longint'(1) << dos_pkg::CNT_W) - 1;
    localparam logic [dos_pkg::CNT_W-1:0] CNT_CAP =
        (longint'(MAX_FRAME_PIXELS) < CNT_MAX) ? dos_pkg::CNT_W'(MAX_FRAME_PIXELS)
                                               : dos_pkg::CNT_W'(CNT_MAX);

    function automatic logic [dos_pkg::CNT_W-1:0] inc_sat(
        input logic [dos_pkg::CNT_W-1:0] v
    );
        return (v >= CNT_CAP) ? CNT_CAP : v + 1'b1;
    endfunction

    function automatic logic [dos_pkg::ERR_W-1:0] add_sat(
        input logic [dos_pkg::ERR_W-1:0] acc,
        input logic [15:0]               v
    );
        logic [dos_pkg::ERR_W:0] s;
        s = {1'b0, acc} + (dos_pkg::ERR_W + 1)'(v);
        return s[dos_pkg::ERR_W] ? {dos_pkg::ERR_W{1'b1}} : s[dos_pkg::ERR_W-1:0];
    endfunction

    logic [dos_pkg::CNT_W-1:0] r_gt_cnt, n_gt_cnt;
    logic [dos_pkg::CNT_W-1:0] r_gen_cnt, n_gen_cnt;
    logic [dos_pkg::THR_MAX-1:0][dos_pkg::CNT_W-1:0] r_all_out, n_all_out;
    logic [dos_pkg::THR_MAX-1:0][dos_pkg::CNT_W-1:0] r_gen_out, n_gen_out;
    logic [dos_pkg::ERR_W-1:0] r_err_all, n_err_all;
    logic [dos_pkg::ERR_W-1:0] r_err_gen, n_err_gen;
    logic                      r_out_valid;
    dos_pkg::t_out_word        r_out_word;

    logic out_free;
    logic fire;
    logic cnt;
    logic cnt_gen;
    logic hit;

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_take   = !i_prod.frame_end || out_free;
    assign fire     = i_valid && o_take;

    always_comb begin
        cnt     = i_prod.counted;
        cnt_gen = i_prod.counted && i_prod.gen_ok;
        n_gt_cnt  = cnt ? inc_sat(r_gt_cnt) : r_gt_cnt;
        n_gen_cnt = cnt_gen ? inc_sat(r_gen_cnt) : r_gen_cnt;
        n_err_all = cnt ? add_sat(r_err_all, i_prod.err) : r_err_all;
        n_err_gen = cnt_gen ? add_sat(r_err_gen, i_prod.err) : r_err_gen;
        for (int k = 0; k < dos_pkg::THR_MAX; k++) begin
            hit = (k < NUM_THRESHOLDS)
                  && (dos_pkg::RHS_W'(i_prod.lhs) >= i_prod.rhs[k]);
            n_all_out[k] = (cnt && hit) ? inc_sat(r_all_out[k]) : r_all_out[k];
            n_gen_out[k] = (cnt_gen && hit) ? inc_sat(r_gen_out[k]) : r_gen_out[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gt_cnt  <= '0;
            r_gen_cnt <= '0;
            r_all_out <= '0;
            r_gen_out <= '0;
            r_err_all <= '0;
            r_err_gen <= '0;
        end else if (fire) begin
            if (i_prod.frame_end) begin
                r_gt_cnt  <= '0;
                r_gen_cnt <= '0;
                r_all_out <= '0;
                r_gen_out <= '0;
                r_err_all <= '0;
                r_err_gen <= '0;
            end else begin
                r_gt_cnt  <= n_gt_cnt;
                r_gen_cnt <= n_gen_cnt;
                r_all_out <= n_all_out;
                r_gen_out <= n_gen_out;
                r_err_all <= n_err_all;
                r_err_gen <= n_err_gen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && i_prod.frame_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && i_prod.frame_end) begin
            r_out_word.valid_gt_count      <= n_gt_cnt;
            r_out_word.valid_gen_count     <= n_gen_cnt;
            r_out_word.outliers_all_first  <= n_all_out[0];
            r_out_word.outliers_all_second <= n_all_out[1];
            r_out_word.outliers_all_third  <= n_all_out[2];
            r_out_word.outliers_all_fourth <= n_all_out[3];
            r_out_word.outliers_gen_first  <= n_gen_out[0];
            r_out_word.outliers_gen_second <= n_gen_out[1];
            r_out_word.outliers_gen_third  <= n_gen_out[2];
            r_out_word.outliers_gen_fourth <= n_gen_out[3];
            r_out_word.error_sum_all       <= n_err_all;
            r_out_word.error_sum_gen       <= n_err_gen;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
